// ----- rtl/core/btpc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the bracketed time packet clock.
// Holds the shared constants, the result struct of the packet parser and
// the two-digit decimal helper. No dependencies.
package btpc_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 16;
  localparam int unsigned STORE_DEPTH    = 6;
  localparam int unsigned STORE_IDX_W    = 3;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned TIME_W         = 7;
  localparam int unsigned COUNT_W        = 4;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TIME_W-1:0] HOUR_RESET   = TIME_W'(8);
  localparam logic [TIME_W-1:0] SEC_PER_MIN  = TIME_W'(60);
  localparam logic [TIME_W-1:0] MIN_PER_HOUR = TIME_W'(60);
  localparam logic [TIME_W-1:0] HOUR_PER_DAY = TIME_W'(24);

  typedef struct packed {
    logic              load;
    logic [TIME_W-1:0] hours;
    logic [TIME_W-1:0] minutes;
    logic [TIME_W-1:0] seconds;
    logic [COUNT_W-1:0] count;
    logic              in_packet;
  } pkt_res_t;

  // Tens digit times ten plus units digit.
  function automatic logic [TIME_W-1:0] two_digit(input logic [DIGIT_W-1:0] tens,
                                                  input logic [DIGIT_W-1:0] units);
    logic [TIME_W-1:0] r;
    r = TIME_W'(tens) * TIME_W'(10) + TIME_W'(units);
    return r;
  endfunction

endpackage

// ----- rtl/core/btpc_packet.sv -----
`timescale 1ns / 1ps
// Packet parser: open/close tracking, digit position and the digit store.
// Depends on btpc_pkg.
module btpc_packet import btpc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       op_i,
  input  logic [7:0] byte_i,
  output pkt_res_t   res_o
);

  localparam int unsigned POS_W = $clog2(MAX_DIGITS);

  logic                      recv_q, recv_d;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic [POS_W:0]            pos_inc;
  logic [DIGIT_W-1:0]        store_q [STORE_DEPTH];
  logic [DIGIT_W-1:0]        store_d [STORE_DEPTH];

  always_comb begin
    recv_d  = recv_q;
    pos_d   = pos_q;
    store_d = store_q;
    pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);
    res_o.load  = 1'b0;
    res_o.count = '0;
    if (op_i == OP_BYTE) begin
      if (byte_i == CH_OPEN) begin
        recv_d  = 1'b1;
        pos_d   = '0;
        store_d = '{default: '0};
      end else if (byte_i == CH_CLOSE) begin
        // The store is kept, so a later close without an open reloads it.
        res_o.load  = 1'b1;
        res_o.count = COUNT_W'(pos_q);
        recv_d      = 1'b0;
        pos_d       = '0;
      end else if (recv_q) begin
        if (byte_i inside {[CH_ZERO:CH_NINE]}) begin
          if (pos_q < POS_W'(STORE_DEPTH)) begin
            store_d[pos_q[STORE_IDX_W-1:0]] = byte_i[DIGIT_W-1:0];
          end
          if (pos_inc >= (POS_W+1)'(MAX_DIGITS)) begin
            recv_d  = 1'b0;
            pos_d   = '0;
            store_d = '{default: '0};
          end else begin
            pos_d = pos_inc[POS_W-1:0];
          end
        end else if (byte_i != CH_COMMA) begin
          recv_d  = 1'b0;
          pos_d   = '0;
          store_d = '{default: '0};
        end
      end
    end
    res_o.hours     = two_digit(store_q[0], store_q[1]);
    res_o.minutes   = two_digit(store_q[2], store_q[3]);
    res_o.seconds   = two_digit(store_q[4], store_q[5]);
    res_o.in_packet = recv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q  <= 1'b0;
      pos_q   <= '0;
      store_q <= '{default: '0};
    end else if (step_i) begin
      recv_q  <= recv_d;
      pos_q   <= pos_d;
      store_q <= store_d;
    end
  end

endmodule

// ----- rtl/core/btpc_clock.sv -----
`timescale 1ns / 1ps
// Time-of-day counters: load from a closed packet or advance by one second.
// Depends on btpc_pkg.
module btpc_clock import btpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              tick_i,
  input  pkt_res_t          pkt_i,
  output logic [TIME_W-1:0] hours_o,
  output logic [TIME_W-1:0] minutes_o,
  output logic [TIME_W-1:0] seconds_o
);

  logic [TIME_W-1:0] hour_q, hour_d;
  logic [TIME_W-1:0] min_q, min_d;
  logic [TIME_W-1:0] sec_q, sec_d;
  logic [TIME_W-1:0] sec_inc, min_inc, hour_inc;

  always_comb begin
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    sec_inc  = sec_q + TIME_W'(1);
    min_inc  = min_q + TIME_W'(1);
    hour_inc = hour_q + TIME_W'(1);
    if (tick_i) begin
      // Loaded values may be out of range; any value at or above the
      // limit wraps to zero on the next carry.
      if (sec_inc >= SEC_PER_MIN) begin
        sec_d = '0;
        if (min_inc >= MIN_PER_HOUR) begin
          min_d  = '0;
          hour_d = (hour_inc >= HOUR_PER_DAY) ? '0 : hour_inc;
        end else begin
          min_d = min_inc;
        end
      end else begin
        sec_d = sec_inc;
      end
    end else if (pkt_i.load) begin
      hour_d = pkt_i.hours;
      min_d  = pkt_i.minutes;
      sec_d  = pkt_i.seconds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q <= HOUR_RESET;
      min_q  <= '0;
      sec_q  <= '0;
    end else if (step_i) begin
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
    end
  end

  assign hours_o   = hour_d;
  assign minutes_o = min_d;
  assign seconds_o = sec_d;

endmodule

// ----- rtl/core/bracketed_time_packet_clock_unit.sv -----
`timescale 1ns / 1ps
// Time-of-day clock set by bracketed serial packets such as "[hh,mm,ss]".
// Each input beat is either a received byte or a one-second tick, and each
// beat yields exactly one result beat carrying the time after that step.
// A beat passes an input register and then the parser and counter logic
// into the result register, and one beat is taken every cycle unless the
// result stalls; while a finished result waits under stall the input
// register still takes one more beat, and the input stalls only once both
// registers hold a beat. Depends on btpc_pkg, btpc_packet, btpc_clock.
module bracketed_time_packet_clock_unit import btpc_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TIME_W-1:0]  hours_o,
  output logic [TIME_W-1:0]  minutes_o,
  output logic [TIME_W-1:0]  seconds_o,
  output logic               time_loaded_o,
  output logic [COUNT_W-1:0] digit_count_o,
  output logic               in_packet_o
);

  logic              in_valid_q, in_valid_d;
  logic              op_q;
  logic [7:0]        byte_q;
  logic              out_valid_q, out_valid_d;
  logic              accept, advance;
  pkt_res_t          pkt_res;
  logic [TIME_W-1:0] hours_d, minutes_d, seconds_d;
  logic [TIME_W-1:0] hours_q, minutes_q, seconds_q;
  logic              loaded_q;
  logic [COUNT_W-1:0] count_q;
  logic              in_packet_q;

  // A held beat moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  btpc_packet #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_packet (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .op_i   (op_q),
    .byte_i (byte_q),
    .res_o  (pkt_res)
  );

  btpc_clock u_clock (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .tick_i    (op_q == OP_TICK),
    .pkt_i     (pkt_res),
    .hours_o   (hours_d),
    .minutes_o (minutes_d),
    .seconds_o (seconds_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hours_q     <= hours_d;
      minutes_q   <= minutes_d;
      seconds_q   <= seconds_d;
      loaded_q    <= pkt_res.load;
      count_q     <= pkt_res.count;
      in_packet_q <= pkt_res.in_packet;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hours_o       = hours_q;
  assign minutes_o     = minutes_q;
  assign seconds_o     = seconds_q;
  assign time_loaded_o = loaded_q;
  assign digit_count_o = count_q;
  assign in_packet_o   = in_packet_q;

`ifndef ASSERT_OFF
  a_stall_needs_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q) else $error("input stalled with no held beat");

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q) else $error("result register not filled after advance");

  a_load_closes_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && time_loaded_o) |-> !in_packet_o)
    else $error("packet still open after a load");

  a_count_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (digit_count_o != '0)) |-> time_loaded_o)
    else $error("digit count reported without a load");
`endif

endmodule

// ----- bench/tb_bracketed_time_packet_clock_unit.sv -----
`timescale 1ns / 1ps
// Testbench for bracketed_time_packet_clock_unit: drives serial bytes and ticks with random
// gaps and result stalls, and checks every result beat against a time-of-day predictor.
// Depends on btpc_pkg and the unit itself.
module tb_bracketed_time_packet_clock_unit import btpc_pkg::*; ();

  localparam int unsigned DIGIT_LIMIT = MAX_DIGITS_DEF;
  localparam int          ITEMS       = 750;
  localparam int          CALM_ITEMS  = 100;

  class clock_scoreboard;
    bit                 receiving;
    int unsigned        digit_pos;
    logic [DIGIT_W-1:0] digits [STORE_DEPTH];
    int unsigned        hour_cnt;
    int unsigned        min_cnt;
    int unsigned        sec_cnt;
    pkt_res_t           pending_times [$];
    int                 mismatches;

    function new();
      drop_packet();
      hour_cnt   = HOUR_RESET;
      min_cnt    = 0;
      sec_cnt    = 0;
      mismatches = 0;
    endfunction

    function void drop_packet();
      receiving = 1'b0;
      digit_pos = 0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    // Advances the clock or the packet parser by one accepted beat and queues the time
    // that the unit must report for it.
    function void predict_beat(logic op, logic [7:0] b);
      pkt_res_t r;
      r = '0;
      if (op == OP_TICK) begin
        sec_cnt++;
        if (sec_cnt >= SEC_PER_MIN) begin
          sec_cnt = 0;
          min_cnt++;
          if (min_cnt >= MIN_PER_HOUR) begin
            min_cnt = 0;
            hour_cnt++;
            if (hour_cnt >= HOUR_PER_DAY) hour_cnt = 0;
          end
        end
      end else if (b == CH_OPEN) begin
        drop_packet();
        receiving = 1'b1;
      end else if (b == CH_CLOSE) begin
        // A close with no open packet still loads whatever the store holds.
        r.count   = COUNT_W'(digit_pos);
        r.load    = 1'b1;
        receiving = 1'b0;
        digit_pos = 0;
        hour_cnt  = digits[0] * 10 + digits[1];
        min_cnt   = digits[2] * 10 + digits[3];
        sec_cnt   = digits[4] * 10 + digits[5];
      end else if (receiving) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          if (digit_pos < STORE_DEPTH) digits[digit_pos] = DIGIT_W'(b - CH_ZERO);
          digit_pos++;
          if (digit_pos >= DIGIT_LIMIT) drop_packet();
        end else if (b != CH_COMMA) begin
          drop_packet();
        end
      end
      r.hours     = TIME_W'(hour_cnt);
      r.minutes   = TIME_W'(min_cnt);
      r.seconds   = TIME_W'(sec_cnt);
      r.in_packet = receiving;
      pending_times.push_back(r);
    endfunction

    function void check_time(pkt_res_t got);
      pkt_res_t want;
      if (pending_times.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %0d:%0d:%0d", got.hours, got.minutes,
                   got.seconds);
        return;
      end
      want = pending_times.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %0d:%0d:%0d load=%0b count=%0d pkt=%0b",
                   want.hours, want.minutes, want.seconds, want.load, want.count,
                   want.in_packet);
          $display("          got      %0d:%0d:%0d load=%0b count=%0d pkt=%0b",
                   got.hours, got.minutes, got.seconds, got.load, got.count,
                   got.in_packet);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               operation_i;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [TIME_W-1:0]  hours_o;
  logic [TIME_W-1:0]  minutes_o;
  logic [TIME_W-1:0]  seconds_o;
  logic               time_loaded_o;
  logic [COUNT_W-1:0] digit_count_o;
  logic               in_packet_o;

  clock_scoreboard sb;
  int              sent;
  bit              calm;

  bracketed_time_packet_clock_unit #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hours_o       (hours_o),
    .minutes_o     (minutes_o),
    .seconds_o     (seconds_o),
    .time_loaded_o (time_loaded_o),
    .digit_count_o (digit_count_o),
    .in_packet_o   (in_packet_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Inputs and outputs are sampled at the edge; all drivers use nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.predict_beat(operation_i, rx_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_time('{load: time_loaded_o, hours: hours_o, minutes: minutes_o,
                        seconds: seconds_o, count: digit_count_o, in_packet: in_packet_o});
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Sends an open bracket and n digits with commas and stray ticks mixed in. A broken
  // packet ends in a foreign byte instead of the close, now and then followed by a close.
  task automatic send_packet(input int n, input bit near_midnight, input bit broken);
    logic [7:0] d;
    logic [7:0] junk;
    string      late_digits;
    late_digits = "23595";
    send_beat(OP_BYTE, CH_OPEN);
    for (int i = 0; i < n; i++) begin
      if (near_midnight && i < 5) d = late_digits[i];
      else d = CH_ZERO + 8'($urandom_range(0, 9));
      send_beat(OP_BYTE, d);
      if (i % 2 == 1 && $urandom_range(0, 2) == 0) send_beat(OP_BYTE, CH_COMMA);
      if ($urandom_range(0, 19) == 0) send_tick();
    end
    if (broken) begin
      do junk = 8'($urandom_range(0, 255));
      while ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_COMMA ||
             junk == CH_OPEN || junk == CH_CLOSE);
      send_beat(OP_BYTE, junk);
      if ($urandom_range(0, 2) == 0) send_beat(OP_BYTE, CH_CLOSE);
    end else begin
      send_beat(OP_BYTE, CH_CLOSE);
    end
  endtask

  initial begin
    int  pick;
    int  n;
    bit  paused;
    sb          = new();
    sent        = 0;
    calm        = 1'b0;
    paused      = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_BYTE;
    rx_byte_i   <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: tick from reset, a full packet of nines and the wrap of all three
    // counters, a close with no open, a restart inside a packet, an abort on a zero byte,
    // a load of the cleared store, and bytes outside a packet.
    send_tick();
    send_beat(OP_BYTE, CH_OPEN);
    send_beat(OP_BYTE, "9");
    send_beat(OP_BYTE, "9");
    send_beat(OP_BYTE, CH_COMMA);
    repeat (4) send_beat(OP_BYTE, "9");
    send_beat(OP_BYTE, CH_CLOSE);
    send_tick();
    send_beat(OP_BYTE, CH_CLOSE);
    send_beat(OP_BYTE, CH_OPEN);
    send_beat(OP_BYTE, "1");
    send_beat(OP_BYTE, CH_OPEN);
    send_beat(OP_BYTE, "2");
    send_beat(OP_BYTE, CH_CLOSE);
    send_beat(OP_BYTE, CH_OPEN);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, CH_CLOSE);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, "5");
    send_beat(OP_TICK, 8'hFF);

    while (sent < ITEMS) begin
      calm = (sent >= ITEMS - CALM_ITEMS);
      if (!paused && sent >= ITEMS / 2) begin
        // Let the unit drain completely once before carrying on.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_times.size() != 0) @(posedge clk_i);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: n = 6;
          6, 7:             n = $urandom_range(0, 8);
          8:                n = $urandom_range(9, DIGIT_LIMIT + 2);
          default:          n = $urandom_range(DIGIT_LIMIT - 1, DIGIT_LIMIT);
        endcase
        send_packet(n, $urandom_range(0, 3) == 0, pick >= 11);
      end else if (pick < 17) begin
        if ($urandom_range(0, 7) == 0) n = $urandom_range(60, 130);
        else n = $urandom_range(1, 5);
        repeat (n) send_tick();
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_times.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
